// ----- hdl/lapc_pkg.sv -----
// ----------------------------------------------------------------------------
// lapc_pkg
// Shared widths, codes and control structs of the actuator position controller.
// ----------------------------------------------------------------------------
package lapc_pkg;

	localparam int REQ_W      = 2;
	localparam int TGT_W      = 10;
	localparam int DIR_W      = 2;
	localparam int POWER_W    = 8;
	localparam int MODE_W     = 2;
	localparam int STROKE_W   = 10;
	localparam int TOL_W      = 6;
	localparam int STABLE_W   = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;

	typedef enum logic [REQ_W-1:0] {
		REQ_TICK = 2'd0,
		REQ_CAL  = 2'd1,
		REQ_SET  = 2'd2
	} lapc_req_t;

	typedef enum logic [DIR_W-1:0] {
		DIR_STOP    = 2'd0,
		DIR_EXTEND  = 2'd1,
		DIR_RETRACT = 2'd2
	} lapc_dir_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_IDLE    = 2'd0,
		MODE_CAL_OUT = 2'd1,
		MODE_CAL_IN  = 2'd2,
		MODE_POS     = 2'd3
	} lapc_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAX_POWER   = 2'd0,
		CFG_FULL_STROKE = 2'd1,
		CFG_TOLERANCE   = 2'd2,
		CFG_STABLE      = 2'd3
	} lapc_cfg_t;

	localparam logic [POWER_W-1:0]  RST_MAX_POWER   = 8'd255;
	localparam logic [STROKE_W-1:0] RST_FULL_STROKE = 10'd200;
	localparam logic [TOL_W-1:0]    RST_TOLERANCE   = 6'd1;
	localparam logic [STABLE_W-1:0] RST_STABLE      = 8'd20;
	localparam logic [STABLE_W-1:0] STABLE_SAT      = 8'd255;

	// controller to datapath
	typedef struct packed {
		logic capture;      // latch the accepted request
		logic exec_commit;  // apply tick / calibrate / unused request, load result
		logic mul_load;     // clamp target and register the span product
		logic div_init;     // seed the long division
		logic div_step;     // one quotient bit
		logic tgt_commit;   // write target, enter positioning, load result
	} lapc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic req_is_set;
	} lapc_status_t;

endpackage

// ----- hdl/lapc_cfg_if.sv -----
// ----------------------------------------------------------------------------
// lapc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface lapc_cfg_if import lapc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  reg_index;
	logic [CFG_DATA_W-1:0] wdata;

	modport source (output valid, reg_index, wdata, input ready);
	modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ----- hdl/lapc_req_if.sv -----
// ----------------------------------------------------------------------------
// lapc_req_if
// Request channel: sample tick, start calibration or set target.
// ----------------------------------------------------------------------------
interface lapc_req_if import lapc_pkg::*; #(
	parameter int ADC_BITS = 10
) ();
	logic                valid;
	logic                ready;
	logic [REQ_W-1:0]    req_type;
	logic [ADC_BITS-1:0] adc_sample;
	logic [TGT_W-1:0]    target_mm;

	modport source (output valid, req_type, adc_sample, target_mm, input ready);
	modport sink   (input valid, req_type, adc_sample, target_mm, output ready);
endinterface

// ----- hdl/lapc_rsp_if.sv -----
// ----------------------------------------------------------------------------
// lapc_rsp_if
// Result channel: motor direction, duty, mode and at-target flag.
// ----------------------------------------------------------------------------
interface lapc_rsp_if import lapc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [DIR_W-1:0]   drive_dir;
	logic [POWER_W-1:0] drive_power;
	logic [MODE_W-1:0]  mode_now;
	logic               at_target;

	modport source (output valid, drive_dir, drive_power, mode_now, at_target, input ready);
	modport sink   (input valid, drive_dir, drive_power, mode_now, at_target, output ready);
endinterface

// ----- hdl/lapc_ctrl.sv -----
// ----------------------------------------------------------------------------
// lapc_ctrl
// Sequencer: request acceptance, division step count, result valid.
// ----------------------------------------------------------------------------
module lapc_ctrl import lapc_pkg::*; #(
	parameter int ADC_BITS = 10
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         req_valid,
	output logic         req_ready,
	output logic         rsp_valid,
	input  logic         rsp_ready,
	input  lapc_status_t status,
	output lapc_cmd_t    cmd
);

	localparam int CNT_W = $clog2(ADC_BITS);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_EXEC = 5'b00010,
		ST_LOAD = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_DONE = 5'b10000
	} lapc_state_t;

	lapc_state_t      state_q, state_nx;
	logic [CNT_W-1:0] cnt_q;
	logic             rsp_valid_q;
	logic             out_free;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_nx    = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (status.req_is_set) begin
					cmd.mul_load = 1'b1;
					state_nx     = ST_LOAD;
				end else if (out_free) begin
					cmd.exec_commit = 1'b1;
					state_nx        = ST_IDLE;
				end
			end
			ST_LOAD: begin
				cmd.div_init = 1'b1;
				state_nx     = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == '0) begin
					state_nx = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.tgt_commit = 1'b1;
					state_nx       = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.div_init) begin
				cnt_q <= CNT_W'(ADC_BITS - 1);
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.exec_commit || cmd.tgt_commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- hdl/lapc_dpath.sv -----
// ----------------------------------------------------------------------------
// lapc_dpath
// Datapath: configuration, calibration state, target mapping, result register.
// ----------------------------------------------------------------------------
module lapc_dpath import lapc_pkg::*; #(
	parameter int ADC_BITS = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic [REQ_W-1:0]      req_type,
	input  logic [ADC_BITS-1:0]   adc_sample,
	input  logic [TGT_W-1:0]      target_mm,
	input  lapc_cmd_t             cmd,
	output lapc_status_t          status,
	output logic [DIR_W-1:0]      drive_dir,
	output logic [POWER_W-1:0]    drive_power,
	output logic [MODE_W-1:0]     mode_now,
	output logic                  at_target
);

	localparam int PW = TGT_W + ADC_BITS;

	// configuration
	logic [POWER_W-1:0]  max_power_q;
	logic [STROKE_W-1:0] stroke_q;
	logic [TOL_W-1:0]    tol_q;
	logic [STABLE_W-1:0] stable_q;

	// controller state
	lapc_mode_t          mode_q;
	logic [ADC_BITS-1:0] prev_q;
	logic                prev_valid_q;
	logic [STABLE_W-1:0] cnt_q;
	logic [ADC_BITS-1:0] upper_q;
	logic [ADC_BITS-1:0] lower_q;
	logic [ADC_BITS-1:0] target_q;

	// latched request
	logic [REQ_W-1:0]    in_type_q;
	logic [ADC_BITS-1:0] in_sample_q;
	logic [TGT_W-1:0]    in_tgt_q;

	// mapping
	logic [PW-1:0]       prod_q;
	logic                neg_q;
	logic [STROKE_W-1:0] rem_q;
	logic [ADC_BITS-1:0] quo_q;

	// result
	logic [DIR_W-1:0]    out_dir_q;
	logic [POWER_W-1:0]  out_power_q;
	logic [MODE_W-1:0]   out_mode_q;
	logic                out_at_q;

	logic                same, end_stop, near;
	logic [STABLE_W-1:0] cnt_inc, cnt_nx;
	logic [ADC_BITS-1:0] mag;
	lapc_dir_t           dir_raw;
	logic                at_nx;
	lapc_mode_t          mode_nx;
	logic [TGT_W-1:0]    t_cl;
	logic                span_neg;
	logic [ADC_BITS-1:0] abs_span;
	logic [STROKE_W:0]   trial, trial_diff;
	logic                ge;
	logic [ADC_BITS-1:0] tgt_nx;
	logic                drive_on;

	assign status.req_is_set = (in_type_q == REQ_SET);

	// tick, calibrate and unused request
	always_comb begin
		same     = prev_valid_q && (prev_q == in_sample_q);
		cnt_inc  = (cnt_q == STABLE_SAT) ? cnt_q : cnt_q + 1'b1;
		cnt_nx   = same ? cnt_inc : '0;
		end_stop = same && (cnt_nx >= stable_q);
		mag      = (target_q >= in_sample_q) ? target_q - in_sample_q
		                                     : in_sample_q - target_q;
		near     = mag < {{(ADC_BITS-TOL_W){1'b0}}, tol_q};
		dir_raw  = DIR_STOP;
		at_nx    = 1'b0;
		mode_nx  = mode_q;
		case (in_type_q)
			REQ_CAL: begin
				mode_nx = MODE_CAL_OUT;
				dir_raw = DIR_EXTEND;
			end
			REQ_TICK: begin
				case (mode_q)
					MODE_CAL_OUT: begin
						if (end_stop) begin
							mode_nx = MODE_CAL_IN;
							dir_raw = DIR_RETRACT;
						end else begin
							dir_raw = DIR_EXTEND;
						end
					end
					MODE_CAL_IN: begin
						if (end_stop) begin
							mode_nx = MODE_IDLE;
						end else begin
							dir_raw = DIR_RETRACT;
						end
					end
					MODE_POS: begin
						if (near) begin
							mode_nx = MODE_IDLE;
							at_nx   = 1'b1;
						end else if (target_q > in_sample_q) begin
							dir_raw = DIR_EXTEND;
						end else if (target_q < in_sample_q) begin
							dir_raw = DIR_RETRACT;
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
		drive_on = (dir_raw != DIR_STOP) && (max_power_q != '0);
	end

	// target mapping: clamp, multiply by span magnitude, divide by stroke, offset from lower_q
	always_comb begin
		t_cl       = (in_tgt_q > stroke_q) ? stroke_q : in_tgt_q;
		span_neg   = upper_q < lower_q;
		abs_span   = span_neg ? lower_q - upper_q : upper_q - lower_q;
		trial      = {rem_q, quo_q[ADC_BITS-1]};
		trial_diff = trial - {1'b0, stroke_q};
		ge         = trial >= {1'b0, stroke_q};
		if (stroke_q == '0) begin
			tgt_nx = lower_q;
		end else if (neg_q) begin
			tgt_nx = lower_q - quo_q;
		end else begin
			tgt_nx = lower_q + quo_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_power_q  <= RST_MAX_POWER;
			stroke_q     <= RST_FULL_STROKE;
			tol_q        <= RST_TOLERANCE;
			stable_q     <= RST_STABLE;
			mode_q       <= MODE_IDLE;
			prev_q       <= '0;
			prev_valid_q <= 1'b0;
			cnt_q        <= '0;
			upper_q      <= '1;
			lower_q      <= '0;
			target_q     <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_MAX_POWER:   max_power_q <= cfg_wdata[POWER_W-1:0];
					CFG_FULL_STROKE: stroke_q    <= cfg_wdata[STROKE_W-1:0];
					CFG_TOLERANCE:   tol_q       <= cfg_wdata[TOL_W-1:0];
					CFG_STABLE:      stable_q    <= cfg_wdata[STABLE_W-1:0];
					default: begin
					end
				endcase
			end
			if (cmd.exec_commit) begin
				mode_q <= mode_nx;
				if (in_type_q == REQ_CAL) begin
					prev_valid_q <= 1'b0;
					cnt_q        <= '0;
				end else if ((in_type_q == REQ_TICK) &&
				             ((mode_q == MODE_CAL_OUT) || (mode_q == MODE_CAL_IN))) begin
					prev_q       <= in_sample_q;
					prev_valid_q <= 1'b1;
					cnt_q        <= end_stop ? '0 : cnt_nx;
					if (end_stop && (mode_q == MODE_CAL_OUT)) begin
						upper_q <= in_sample_q;
					end
					if (end_stop && (mode_q == MODE_CAL_IN)) begin
						lower_q <= in_sample_q;
					end
				end
			end
			if (cmd.tgt_commit) begin
				target_q <= tgt_nx;
				mode_q   <= MODE_POS;
			end
		end
	end

	// request latch, division and result payload: no reset needed
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_type_q   <= req_type;
			in_sample_q <= adc_sample;
			in_tgt_q    <= target_mm;
		end
		if (cmd.mul_load) begin
			prod_q <= PW'(t_cl) * PW'(abs_span);
			neg_q  <= span_neg;
		end
		if (cmd.div_init) begin
			rem_q <= prod_q[PW-1:ADC_BITS];
			quo_q <= prod_q[ADC_BITS-1:0];
		end else if (cmd.div_step) begin
			rem_q <= ge ? trial_diff[STROKE_W-1:0] : trial[STROKE_W-1:0];
			quo_q <= {quo_q[ADC_BITS-2:0], ge};
		end
		if (cmd.exec_commit) begin
			out_dir_q   <= drive_on ? dir_raw : DIR_STOP;
			out_power_q <= drive_on ? max_power_q : '0;
			out_mode_q  <= mode_nx;
			out_at_q    <= at_nx;
		end else if (cmd.tgt_commit) begin
			out_dir_q   <= DIR_STOP;
			out_power_q <= '0;
			out_mode_q  <= MODE_POS;
			out_at_q    <= 1'b0;
		end
	end

	assign drive_dir   = out_dir_q;
	assign drive_power = out_power_q;
	assign mode_now    = out_mode_q;
	assign at_target   = out_at_q;

endmodule

// ----- hdl/linear_actuator_position_controller.sv -----
// ----------------------------------------------------------------------------
// linear_actuator_position_controller
// Bang-bang position loop for a pot-fed linear actuator with end-stop calibration.
// ----------------------------------------------------------------------------
// Usage:
//   req  : one beat per request. req_type 0 is an ADC sample tick (adc_sample),
//          1 starts calibration, 2 sets a target in mm (target_mm).
//   rsp  : exactly one beat per request: drive_dir, drive_power, mode_now and
//          at_target as they stand after that request.
//   cfg  : register writes (max_power, full_stroke_mm, position_tolerance,
//          stable_samples by index 0..3); always ready, write only while idle.
// Sequence:
//   A tick, calibrate or unused request is latched on accept, then evaluated
//   and its result loaded before the next request can be accepted.
//   Set target forms the span product, then runs the long division of the
//   span product by the stroke, one quotient bit per cycle, before loading.
// Reset: control state and configuration go to defaults at once, data registers
//   do not; the first request can be taken in the cycle after arst_n rises.
// Stall: the result sits in an output register; one more request is latched
//   while it waits, and its result load holds until rsp is taken.
// ----------------------------------------------------------------------------
module linear_actuator_position_controller import lapc_pkg::*; #(
	parameter int ADC_BITS = 10
) (
	input logic       clk,
	input logic       arst_n,
	lapc_cfg_if.sink  cfg,
	lapc_req_if.sink  req,
	lapc_rsp_if.source rsp
);

	lapc_cmd_t    cmd;
	lapc_status_t status;

	// configuration writes never stall
	assign cfg.ready = 1'b1;

	// sequencer: accept, division count, result valid
	lapc_ctrl #(
		.ADC_BITS (ADC_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// datapath: registers, calibration, mapping, result payload
	lapc_dpath #(
		.ADC_BITS (ADC_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg.valid && cfg.ready),
		.cfg_index   (cfg.reg_index),
		.cfg_wdata   (cfg.wdata),
		.req_type    (req.req_type),
		.adc_sample  (req.adc_sample),
		.target_mm   (req.target_mm),
		.cmd         (cmd),
		.status      (status),
		.drive_dir   (rsp.drive_dir),
		.drive_power (rsp.drive_power),
		.mode_now    (rsp.mode_now),
		.at_target   (rsp.at_target)
	);

	// duty is nonzero exactly when the motor is driven
	a_power_dir: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> ((rsp.drive_dir == DIR_STOP) == (rsp.drive_power == '0)))
		else $error("drive_power does not match drive_dir");

	// reaching the target stops the motor and drops back to idle
	a_at_target: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.at_target) |->
			((rsp.drive_dir == DIR_STOP) && (rsp.mode_now == MODE_IDLE)))
		else $error("at_target without stop in idle");

	// calibrate-extend mode never reports a retract
	a_cal_dir: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.mode_now == MODE_CAL_OUT)) |-> (rsp.drive_dir != DIR_RETRACT))
		else $error("retract reported in calibrate-extend mode");

	// a new request is taken only once the previous one has been evaluated
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted on back-to-back cycles");

endmodule
